@@ hw/rtl/dio_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dio_pkg;

   // Fixed field widths of the channels
   localparam int DI_MAX     = 6;   // input pins carried by a scan
   localparam int DO_MAX     = 2;   // output pins carried by a result
   localparam int KIND_W     = 2;
   localparam int CH_W       = 3;
   localparam int NOW_W      = 32;
   localparam int TIME_W     = 16;  // one filter or pulse time
   localparam int FILT_A_CH  = 4;   // inputs whose filter time sits in register A
   localparam int FILT_A_W   = FILT_A_CH * TIME_W;
   localparam int FILT_B_W   = 2 * TIME_W;
   localparam int PULSE_W    = DO_MAX * TIME_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Transaction kinds on the request channel
   typedef enum logic [KIND_W-1:0] {
      KIND_SCAN   = 2'd0,
      KIND_SET    = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_TOGGLE = 2'd3
   } kind_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DI_FILTER_A = 3'd0,
      CSR_DI_FILTER_B = 3'd1,
      CSR_DO_PULSE    = 3'd2,
      CSR_DO_MODES    = 3'd3,
      CSR_DI_INVERSE  = 3'd4,
      CSR_DO_INVERSE  = 3'd5
   } csr_index_type;

   // Scan strobe and sample handed to the input filter
   typedef struct packed {
      logic              enable;
      logic [DI_MAX-1:0] pins;
      logic [NOW_W-1:0]  now_ms;
   } dio_scan_type;

endpackage

`default_nettype wire

@@ hw/rtl/dio_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dio_req_if;
   import dio_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [DI_MAX-1:0] di_pins;
   logic [NOW_W-1:0]  now_ms;
   logic [CH_W-1:0]   channel;

   modport source (output valid, kind, di_pins, now_ms, channel, input ready);
   modport sink   (input valid, kind, di_pins, now_ms, channel, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dio_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dio_rsp_if;
   import dio_pkg::*;

   logic              valid;
   logic              ready;
   logic [DI_MAX-1:0] di_status;
   logic              selected_di;
   logic [DO_MAX-1:0] do_pins;
   logic [DO_MAX-1:0] do_request;

   modport source (output valid, di_status, selected_di, do_pins, do_request, input ready);
   modport sink   (input valid, di_status, selected_di, do_pins, do_request, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dio_csr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dio_csr_if;
   import dio_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dio_din.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input debounce: one filter timer per input channel, all updated in parallel.
module dio_din #(
   parameter int INPUT_CHANNELS = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dio_pkg::dio_scan_type         scan,
   input  wire logic [dio_pkg::FILT_A_W-1:0]  filter_times_a,
   input  wire logic [dio_pkg::FILT_B_W-1:0]  filter_times_b,
   output logic      [INPUT_CHANNELS-1:0]     accepted_next
);
   import dio_pkg::*;

   logic [INPUT_CHANNELS-1:0] accepted_ff, accepted_in;
   logic [INPUT_CHANNELS-1:0] running_ff, running_in;

   for (genvar i = 0; i < INPUT_CHANNELS; i++) begin : g_ch
      logic [TIME_W-1:0] ftime;
      logic [NOW_W-1:0]  start_ff;
      logic [NOW_W-1:0]  age;
      logic              acc_n, run_n, load;

      if (i < FILT_A_CH) begin : g_a
         assign ftime = filter_times_a[TIME_W*i +: TIME_W];
      end else begin : g_b
         assign ftime = filter_times_b[TIME_W*(i-FILT_A_CH) +: TIME_W];
      end

      // time since the pin first differed, wraps with the timestamp
      assign age = scan.now_ms - start_ff;

      always_comb begin
         acc_n = accepted_ff[i];
         run_n = running_ff[i];
         load  = 1'b0;
         if (scan.enable) begin
            if (scan.pins[i] != accepted_ff[i]) begin
               if (ftime == '0) begin
                  acc_n = ~accepted_ff[i];
               end else if (!running_ff[i]) begin
                  run_n = 1'b1;
                  load  = 1'b1;
               end else if (age >= NOW_W'(ftime)) begin
                  acc_n = ~accepted_ff[i];
                  run_n = 1'b0;
               end
            end else begin
               run_n = 1'b0;
            end
         end
      end

      assign accepted_in[i] = acc_n;
      assign running_in[i]  = run_n;

      // start stamp is only read while the timer runs
      always_ff @(posedge clock) begin
         if (load) begin
            start_ff <= scan.now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff <= '0;
         running_ff  <= '0;
      end else begin
         accepted_ff <= accepted_in;
         running_ff  <= running_in;
      end
   end

   assign accepted_next = accepted_in;

endmodule

`default_nettype wire

@@ hw/rtl/digital_io_filter_and_pulse.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                      Accepted when
// req_chan  in   kind, di_pins, now_ms, channel               valid && ready
// rsp_chan  out  di_status, selected_di, do_pins, do_request  valid && ready
// csr_chan  in   index, data                                  valid && ready (ready tied high)
//
// Every request transaction yields one response. One transaction per cycle is
// sustained while the response is not stalled: the input register and the result
// register each hold one item, and all channels update in parallel in between.
// A stalled response holds the result register; the input register still takes
// one more transaction, and req_chan.ready drops only while both are full.
// Synchronous active-high reset clears all state and configuration.
module digital_io_filter_and_pulse #(
   parameter int INPUT_CHANNELS  = 6,
   parameter int OUTPUT_CHANNELS = 2
) (
   input wire logic clock,
   input wire logic reset,
   dio_req_if.sink   req_chan,
   dio_rsp_if.source rsp_chan,
   dio_csr_if.sink   csr_chan
);
   import dio_pkg::*;

   // Configuration registers
   logic [FILT_A_W-1:0] di_filter_a_ff;
   logic [FILT_B_W-1:0] di_filter_b_ff;
   logic [PULSE_W-1:0]  do_pulse_ff;
   logic [DO_MAX-1:0]   do_modes_ff;
   logic [DI_MAX-1:0]   di_inverse_ff;
   logic [DO_MAX-1:0]   do_inverse_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         di_filter_a_ff <= '0;
         di_filter_b_ff <= '0;
         do_pulse_ff    <= '0;
         do_modes_ff    <= '0;
         di_inverse_ff  <= '0;
         do_inverse_ff  <= '0;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_DI_FILTER_A: di_filter_a_ff <= csr_chan.data[FILT_A_W-1:0];
            CSR_DI_FILTER_B: di_filter_b_ff <= csr_chan.data[FILT_B_W-1:0];
            CSR_DO_PULSE:    do_pulse_ff    <= csr_chan.data[PULSE_W-1:0];
            CSR_DO_MODES:    do_modes_ff    <= csr_chan.data[DO_MAX-1:0];
            CSR_DI_INVERSE:  di_inverse_ff  <= csr_chan.data[DI_MAX-1:0];
            CSR_DO_INVERSE:  do_inverse_ff  <= csr_chan.data[DO_MAX-1:0];
            default: ;
         endcase
      end
   end

   // Handshake between the input register and the result register
   logic rsp_valid_ff, rsp_valid_in;
   logic stage_valid_ff, stage_valid_in;
   logic rsp_free, stage_fire, req_accept;

   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign stage_fire     = stage_valid_ff && rsp_free;
   assign req_chan.ready = !stage_valid_ff || rsp_free;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_fire) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (stage_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Input register
   kind_type          stage_kind_ff;
   logic [DI_MAX-1:0] stage_pins_ff;
   logic [NOW_W-1:0]  stage_now_ff;
   logic [CH_W-1:0]   stage_channel_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_kind_ff    <= kind_type'(req_chan.kind);
         stage_pins_ff    <= req_chan.di_pins;
         stage_now_ff     <= req_chan.now_ms;
         stage_channel_ff <= req_chan.channel;
      end
   end

   logic stage_scan;
   assign stage_scan = stage_fire && (stage_kind_ff == KIND_SCAN);

   // Input filtering
   dio_scan_type              scan;
   logic [INPUT_CHANNELS-1:0] di_accepted_next;

   assign scan.enable = stage_scan;
   assign scan.pins   = stage_pins_ff;
   assign scan.now_ms = stage_now_ff;

   dio_din #(
      .INPUT_CHANNELS (INPUT_CHANNELS)
   ) u_din (
      .clock          (clock),
      .reset          (reset),
      .scan           (scan),
      .filter_times_a (di_filter_a_ff),
      .filter_times_b (di_filter_b_ff),
      .accepted_next  (di_accepted_next)
   );

   // Output request, level and pulse timers
   logic [OUTPUT_CHANNELS-1:0] do_req_ff, do_req_in;
   logic [OUTPUT_CHANNELS-1:0] do_level_ff, do_level_in;
   logic [OUTPUT_CHANNELS-1:0] do_run_ff, do_run_in;

   for (genvar i = 0; i < OUTPUT_CHANNELS; i++) begin : g_do
      logic [TIME_W-1:0] ptime;
      logic [NOW_W-1:0]  start_ff;
      logic [NOW_W-1:0]  age;
      logic              req_n, lvl_n, run_n, load;

      assign ptime = do_pulse_ff[TIME_W*i +: TIME_W];
      assign age   = stage_now_ff - start_ff;

      always_comb begin
         req_n = do_req_ff[i];
         lvl_n = do_level_ff[i];
         run_n = do_run_ff[i];
         load  = 1'b0;
         if (stage_scan) begin
            if (!do_modes_ff[i]) begin
               // normal mode: level follows the request, timer untouched
               lvl_n = do_req_ff[i];
            end else if (do_req_ff[i]) begin
               if (!do_run_ff[i]) begin
                  run_n = 1'b1;
                  load  = 1'b1;
                  lvl_n = 1'b1;
               end else if (age >= NOW_W'(ptime)) begin
                  req_n = 1'b0;
                  lvl_n = 1'b0;
                  run_n = 1'b0;
               end
            end else if (do_run_ff[i]) begin
               run_n = 1'b0;
               lvl_n = 1'b0;
            end
         end else if (stage_fire && (stage_channel_ff == CH_W'(i))) begin
            case (stage_kind_ff)
               KIND_SET:    req_n = 1'b1;
               KIND_CLEAR:  req_n = 1'b0;
               KIND_TOGGLE: req_n = ~do_req_ff[i];
               default: ;
            endcase
         end
      end

      assign do_req_in[i]   = req_n;
      assign do_level_in[i] = lvl_n;
      assign do_run_in[i]   = run_n;

      always_ff @(posedge clock) begin
         if (load) begin
            start_ff <= stage_now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         do_req_ff   <= '0;
         do_level_ff <= '0;
         do_run_ff   <= '0;
      end else begin
         do_req_ff   <= do_req_in;
         do_level_ff <= do_level_in;
         do_run_ff   <= do_run_in;
      end
   end

   // Result assembly from the updated state
   logic [DI_MAX-1:0]    status_full;
   logic [2**CH_W-1:0]   status_sel;
   logic [DO_MAX-1:0]    pins_full;
   logic [DO_MAX-1:0]    request_full;

   always_comb begin
      status_full  = '0;
      pins_full    = '0;
      request_full = '0;
      for (int i = 0; i < INPUT_CHANNELS; i++) begin
         status_full[i] = di_accepted_next[i] ^ di_inverse_ff[i];
      end
      for (int i = 0; i < OUTPUT_CHANNELS; i++) begin
         pins_full[i]    = do_level_in[i] ^ do_inverse_ff[i];
         request_full[i] = do_req_in[i];
      end
   end

   // channels above the input count read as zero
   assign status_sel = (2**CH_W)'(status_full);

   // Result register
   logic [DI_MAX-1:0] rsp_status_ff;
   logic              rsp_selected_ff;
   logic [DO_MAX-1:0] rsp_pins_ff;
   logic [DO_MAX-1:0] rsp_request_ff;

   always_ff @(posedge clock) begin
      if (stage_fire) begin
         rsp_status_ff   <= status_full;
         rsp_selected_ff <= status_sel[stage_channel_ff];
         rsp_pins_ff     <= pins_full;
         rsp_request_ff  <= request_full;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.di_status   = rsp_status_ff;
   assign rsp_chan.selected_di = rsp_selected_ff;
   assign rsp_chan.do_pins     = rsp_pins_ff;
   assign rsp_chan.do_request  = rsp_request_ff;

endmodule

`default_nettype wire

@@ hw/rtl/dio_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dio_checker #(
   parameter int INPUT_CHANNELS  = 6,
   parameter int OUTPUT_CHANNELS = 2
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [dio_pkg::DI_MAX-1:0] rsp_di_status,
   input wire logic                       rsp_selected_di,
   input wire logic [dio_pkg::DO_MAX-1:0] rsp_do_pins,
   input wire logic [dio_pkg::DO_MAX-1:0] rsp_do_request
);
   import dio_pkg::*;

   // A stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_di_status)
         && $stable(rsp_selected_di) && $stable(rsp_do_pins) && $stable(rsp_do_request))
      else $error("response changed while stalled");

   // No response is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A transaction taken behind a stalled response fills the block
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && req_valid && req_ready) ##1 (rsp_valid && !rsp_ready)
         |-> !req_ready)
      else $error("request taken with both registers full");

   // Bits above the channel counts stay zero
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_di_status >> INPUT_CHANNELS) == '0)
         && ((rsp_do_pins >> OUTPUT_CHANNELS) == '0)
         && ((rsp_do_request >> OUTPUT_CHANNELS) == '0))
      else $error("unused channel bit set in response");

endmodule

bind digital_io_filter_and_pulse dio_checker #(
   .INPUT_CHANNELS  (INPUT_CHANNELS),
   .OUTPUT_CHANNELS (OUTPUT_CHANNELS)
) u_dio_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_di_status   (rsp_chan.di_status),
   .rsp_selected_di (rsp_chan.selected_di),
   .rsp_do_pins     (rsp_chan.do_pins),
   .rsp_do_request  (rsp_chan.do_request)
);

`default_nettype wire

@@ bench/tb_digital_io_filter_and_pulse.sv @@
`timescale 1ns / 1ps

module tb_digital_io_filter_and_pulse;
   import dio_pkg::*;

   localparam int DIRECTED_ROWS   = 26;
   localparam int FIRST_PREDICTED = 11;  // rows before this run with reset settings
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_ITEMS     = 190;
   localparam int STALL_LIMIT     = 400; // cycles without any transaction
   localparam int DRAIN_CYCLES    = 8;

   typedef struct packed {
      logic [DI_MAX-1:0] di_status;
      logic              selected_di;
      logic [DO_MAX-1:0] do_pins;
      logic [DO_MAX-1:0] do_request;
   } io_status_type;

   typedef struct packed {
      kind_type          kind;
      logic [DI_MAX-1:0] pins;
      logic [NOW_W-1:0]  now_ms;
      logic [CH_W-1:0]   channel;
      logic              typed;
      io_status_type     want;
   } script_row_type;

   localparam logic          TYPED     = 1'b1;
   localparam logic          PREDICTED = 1'b0;
   localparam io_status_type NO_WANT   = '0;

   logic clock;
   logic reset;

   dio_req_if req_chan ();
   dio_rsp_if rsp_chan ();
   dio_csr_if csr_chan ();

   digital_io_filter_and_pulse uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Directed rows: reset settings first, then timer, wrap and pulse cases
   script_row_type directed_script [DIRECTED_ROWS] = '{
      '{KIND_SCAN,   6'h00, 32'h0000_0000, 3'd0, TYPED, '{6'h00, 1'b0, 2'd0, 2'd0}},
      '{KIND_SCAN,   6'h3F, 32'h0000_0001, 3'd5, TYPED, '{6'h3F, 1'b1, 2'd0, 2'd0}},
      '{KIND_SCAN,   6'h00, 32'hFFFF_FFFF, 3'd7, TYPED, '{6'h00, 1'b0, 2'd0, 2'd0}},
      '{KIND_SCAN,   6'h2A, 32'h0000_0002, 3'd6, TYPED, '{6'h2A, 1'b0, 2'd0, 2'd0}},
      '{KIND_SET,    6'h00, 32'h0000_0000, 3'd0, TYPED, '{6'h2A, 1'b0, 2'd0, 2'd1}},
      '{KIND_SET,    6'h00, 32'h0000_0000, 3'd1, TYPED, '{6'h2A, 1'b1, 2'd0, 2'd3}},
      '{KIND_SCAN,   6'h2A, 32'h0000_0005, 3'd3, TYPED, '{6'h2A, 1'b1, 2'd3, 2'd3}},
      '{KIND_TOGGLE, 6'h00, 32'h0000_0000, 3'd0, TYPED, '{6'h2A, 1'b0, 2'd3, 2'd2}},
      '{KIND_CLEAR,  6'h00, 32'h0000_0000, 3'd1, TYPED, '{6'h2A, 1'b1, 2'd3, 2'd0}},
      '{KIND_SET,    6'h00, 32'h0000_0000, 3'd7, TYPED, '{6'h2A, 1'b0, 2'd3, 2'd0}},
      '{KIND_TOGGLE, 6'h00, 32'h0000_0000, 3'd2, TYPED, '{6'h2A, 1'b0, 2'd3, 2'd0}},
      '{KIND_SCAN,   6'h3F, 32'h0000_0064, 3'd0, PREDICTED, NO_WANT},
      '{KIND_SCAN,   6'h3F, 32'h0000_0065, 3'd4, PREDICTED, NO_WANT},
      '{KIND_SCAN,   6'h3F, 32'h0000_0067, 3'd2, PREDICTED, NO_WANT},
      '{KIND_SCAN,   6'h3E, 32'h0000_0069, 3'd0, PREDICTED, NO_WANT},
      '{KIND_SCAN,   6'h3F, 32'h0000_0074, 3'd1, PREDICTED, NO_WANT},
      '{KIND_SCAN,   6'h00, 32'hFFFF_FFF8, 3'd1, PREDICTED, NO_WANT},
      '{KIND_SCAN,   6'h00, 32'h0000_0004, 3'd1, PREDICTED, NO_WANT},
      '{KIND_SET,    6'h15, 32'h1234_5678, 3'd0, PREDICTED, NO_WANT},
      '{KIND_TOGGLE, 6'h2A, 32'h8765_4321, 3'd1, PREDICTED, NO_WANT},
      '{KIND_SCAN,   6'h00, 32'h0000_00C8, 3'd0, PREDICTED, NO_WANT},
      '{KIND_SCAN,   6'h00, 32'h0000_00CD, 3'd0, PREDICTED, NO_WANT},
      '{KIND_SET,    6'h00, 32'h0000_0000, 3'd0, PREDICTED, NO_WANT},
      '{KIND_SCAN,   6'h00, 32'h0000_012C, 3'd0, PREDICTED, NO_WANT},
      '{KIND_CLEAR,  6'h00, 32'h0000_0000, 3'd0, PREDICTED, NO_WANT},
      '{KIND_SCAN,   6'h00, 32'h0000_012D, 3'd0, PREDICTED, NO_WANT}
   };

   // Settings copy
   logic [FILT_A_W-1:0] cfg_filt_a = '0;
   logic [FILT_B_W-1:0] cfg_filt_b = '0;
   logic [PULSE_W-1:0]  cfg_pulse  = '0;
   logic [DO_MAX-1:0]   cfg_modes  = '0;
   logic [DI_MAX-1:0]   cfg_di_inv = '0;
   logic [DO_MAX-1:0]   cfg_do_inv = '0;

   // Debounce and pulse state
   logic [DI_MAX-1:0] di_level = '0;
   logic [DI_MAX-1:0] di_held  = '0;
   logic [NOW_W-1:0]  di_since [DI_MAX];
   logic [DO_MAX-1:0] out_req   = '0;
   logic [DO_MAX-1:0] out_level = '0;
   logic [DO_MAX-1:0] out_busy  = '0;
   logic [NOW_W-1:0]  out_since [DO_MAX];

   io_status_type pending_status [$];
   int            mismatches = 0;
   int            quiet_cycles = 0;
   int            gap_pct = 20;
   int            stall_pct = 0;
   int            stall_left = 0;
   int            stall_window = 0;
   logic          calm;
   logic          row_typed;
   io_status_type row_want;

   initial begin
      for (int i = 0; i < DI_MAX; i++) di_since[i] = '0;
      for (int j = 0; j < DO_MAX; j++) out_since[j] = '0;
   end

   // Status after one transaction: debounce and pulse on a scan, request edit on a command
   function automatic io_status_type step_io(input kind_type k, input logic [DI_MAX-1:0] pins,
                                             input logic [NOW_W-1:0] t,
                                             input logic [CH_W-1:0] ch);
      io_status_type     s;
      logic [TIME_W-1:0] span;
      logic [NOW_W-1:0]  gap;
      logic [DI_MAX-1:0] shown;
      if (k == KIND_SCAN) begin
         for (int i = 0; i < DI_MAX; i++) begin
            span = (i < FILT_A_CH) ? cfg_filt_a[TIME_W*i +: TIME_W]
                                   : cfg_filt_b[TIME_W*(i-FILT_A_CH) +: TIME_W];
            gap = t - di_since[i];
            if (pins[i] == di_level[i]) begin
               di_held[i] = 1'b0;
            end else if (span == '0) begin
               di_level[i] = pins[i];
            end else if (!di_held[i]) begin
               di_held[i]  = 1'b1;
               di_since[i] = t;
            end else if (gap >= {16'd0, span}) begin
               di_level[i] = pins[i];
               di_held[i]  = 1'b0;
            end
         end
         for (int j = 0; j < DO_MAX; j++) begin
            span = cfg_pulse[TIME_W*j +: TIME_W];
            gap  = t - out_since[j];
            if (!cfg_modes[j]) begin
               out_level[j] = out_req[j];
            end else if (out_req[j]) begin
               if (!out_busy[j]) begin
                  out_busy[j]  = 1'b1;
                  out_since[j] = t;
                  out_level[j] = 1'b1;
               end else if (gap >= {16'd0, span}) begin
                  out_req[j]   = 1'b0;
                  out_level[j] = 1'b0;
                  out_busy[j]  = 1'b0;
               end
            end else if (out_busy[j]) begin
               out_busy[j]  = 1'b0;
               out_level[j] = 1'b0;
            end
         end
      end else if (ch < DO_MAX) begin
         case (k)
            KIND_SET:   out_req[ch] = 1'b1;
            KIND_CLEAR: out_req[ch] = 1'b0;
            default:    out_req[ch] = ~out_req[ch];
         endcase
      end
      shown         = di_level ^ cfg_di_inv;
      s.di_status   = shown;
      s.selected_di = (ch < DI_MAX) ? shown[ch] : 1'b0;
      s.do_pins     = out_level ^ cfg_do_inv;
      s.do_request  = out_req;
      return s;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatches++;
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Track settings, predict each request transaction, check each response
   always @(posedge clock) begin
      io_status_type got;
      io_status_type want;
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_index_type'(csr_chan.index))
               CSR_DI_FILTER_A: cfg_filt_a = csr_chan.data[FILT_A_W-1:0];
               CSR_DI_FILTER_B: cfg_filt_b = csr_chan.data[FILT_B_W-1:0];
               CSR_DO_PULSE:    cfg_pulse  = csr_chan.data[PULSE_W-1:0];
               CSR_DO_MODES:    cfg_modes  = csr_chan.data[DO_MAX-1:0];
               CSR_DI_INVERSE:  cfg_di_inv = csr_chan.data[DI_MAX-1:0];
               CSR_DO_INVERSE:  cfg_do_inv = csr_chan.data[DO_MAX-1:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            want = step_io(kind_type'(req_chan.kind), req_chan.di_pins, req_chan.now_ms,
                           req_chan.channel);
            pending_status.push_back(row_typed ? row_want : want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.di_status, rsp_chan.selected_di, rsp_chan.do_pins,
                    rsp_chan.do_request};
            if (pending_status.size() == 0) begin
               $error("response transaction with nothing outstanding: %h", got);
               mismatches++;
            end else begin
               want = pending_status.pop_front();
               check_field("di_status", 8'(want.di_status), 8'(got.di_status));
               check_field("selected_di", 8'(want.selected_di), 8'(got.selected_di));
               check_field("do_pins", 8'(want.do_pins), 8'(got.do_pins));
               check_field("do_request", 8'(want.do_request), 8'(got.do_request));
            end
         end
      end
   end

   // Response back-pressure in random bursts, rate redrawn at the start of each window
   always @(posedge clock) begin
      if (stall_window == 0) begin
         stall_window = 40;
         case ($urandom_range(0, 3))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 10;
            default: stall_pct = 30;
         endcase
      end
      stall_window--;
      if (reset || calm) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 5);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Watchdog on transaction progress
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("digital_io_filter_and_pulse regression: fail");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // Drain the block, then rewrite every register; narrow ones get noise above their width
   task automatic load_settings(input logic [FILT_A_W-1:0] fa, input logic [FILT_B_W-1:0] fb,
                                input logic [PULSE_W-1:0] pt, input logic [DO_MAX-1:0] md,
                                input logic [DI_MAX-1:0] di, input logic [DO_MAX-1:0] dq,
                                input bit probe_unused);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
      write_reg(CSR_DI_FILTER_A, fa);
      write_reg(CSR_DI_FILTER_B, {$urandom, fb});
      write_reg(CSR_DO_PULSE, {$urandom, pt});
      write_reg(CSR_DO_MODES, {$urandom, 30'($urandom), md});
      write_reg(CSR_DI_INVERSE, {$urandom, 26'($urandom), di});
      write_reg(CSR_DO_INVERSE, {$urandom, 30'($urandom), dq});
      if (probe_unused) begin
         // indexes past the last register must be ignored
         write_reg(csr_index_type'(CSR_DO_INVERSE + 3'd1), {$urandom, $urandom});
         write_reg(csr_index_type'(CSR_DO_INVERSE + 3'd2), {$urandom, $urandom});
      end
      csr_chan.valid <= 1'b0;
   endtask

   task automatic put_item(input kind_type k, input logic [DI_MAX-1:0] pins,
                           input logic [NOW_W-1:0] t, input logic [CH_W-1:0] ch,
                           input logic typed, input io_status_type want);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.kind    <= k;
      req_chan.di_pins <= pins;
      req_chan.now_ms  <= t;
      req_chan.channel <= ch;
      row_typed        <= typed;
      row_want         <= want;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic logic [TIME_W-1:0] pick_ms();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return TIME_W'($urandom_range(1, 24));
      endcase
   endfunction

   // Stimulus
   initial begin : stimulus
      logic [NOW_W-1:0]    clk_ms;
      logic [DI_MAX-1:0]   pin_level;
      logic [DI_MAX-1:0]   glitch;
      logic [CH_W-1:0]     ch;
      logic [FILT_A_W-1:0] fa;
      logic [FILT_B_W-1:0] fb;
      logic [PULSE_W-1:0]  pt;
      kind_type            k;
      int                  r;
      reset            <= 1'b1;
      calm             <= 1'b0;
      req_chan.valid   <= 1'b0;
      req_chan.kind    <= KIND_SCAN;
      req_chan.di_pins <= '0;
      req_chan.now_ms  <= '0;
      req_chan.channel <= '0;
      csr_chan.valid   <= 1'b0;
      csr_chan.index   <= CSR_DI_FILTER_A;
      csr_chan.data    <= '0;
      row_typed        <= 1'b0;
      row_want         <= NO_WANT;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table; the predicted rows run with mixed filter and pulse settings
      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         if (n == FIRST_PREDICTED)
            load_settings({16'd0, 16'd3, 16'hFFFF, 16'd10}, {16'hFFFF, 16'd1},
                          {16'd0, 16'd5}, 2'b11, 6'h3F, 2'b10, 1'b0);
         put_item(directed_script[n].kind, directed_script[n].pins, directed_script[n].now_ms,
                  directed_script[n].channel, directed_script[n].typed,
                  directed_script[n].want);
      end

      // Random phases: all-max settings, all-zero settings, then random settings
      pin_level = '0;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0) begin
            load_settings('1, '1, '1, '1, '1, '1, 1'b0);
         end else if (ph == 1) begin
            load_settings('0, '0, '0, '0, '0, '0, 1'b1);
         end else begin
            fa = {pick_ms(), pick_ms(), pick_ms(), pick_ms()};
            fb = {pick_ms(), pick_ms()};
            pt = {pick_ms(), pick_ms()};
            load_settings(fa, fb, pt, 2'($urandom), 6'($urandom), 2'($urandom), 1'b0);
         end
         if (ph == RANDOM_PHASES - 1)
            calm <= 1'b1;
         clk_ms = (ph == 2) ? 32'hFFFF_FF00 : $urandom;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 32 == 0) begin
               case ($urandom_range(0, 3))
                  0:       gap_pct = 0;
                  1:       gap_pct = 10;
                  2:       gap_pct = 25;
                  default: gap_pct = 50;
               endcase
            end
            if ($urandom_range(0, 99) < 70) begin
               // scan: clock mostly creeps forward, sometimes jumps past long filters
               r = $urandom_range(0, 99);
               if (r < 3)
                  clk_ms = $urandom;
               else if (r < 8)
                  clk_ms = clk_ms + $urandom_range(0, 70000);
               else
                  clk_ms = clk_ms + $urandom_range(0, 12);
               // pins: lasting edges, single-scan glitches, otherwise steady
               r = $urandom_range(0, 99);
               glitch = '0;
               if (r < 12)
                  pin_level = pin_level ^ DI_MAX'($urandom);
               else if (r < 22)
                  glitch = DI_MAX'($urandom);
               put_item(KIND_SCAN, pin_level ^ glitch, clk_ms, CH_W'($urandom_range(0, 7)),
                        PREDICTED, NO_WANT);
            end else begin
               k  = kind_type'(KIND_W'($urandom_range(1, 3)));
               ch = ($urandom_range(0, 9) < 8) ? CH_W'($urandom_range(0, 1))
                                               : CH_W'($urandom_range(0, 7));
               put_item(k, DI_MAX'($urandom), $urandom, ch, PREDICTED, NO_WANT);
            end
         end
      end

      // Drain and report
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("digital_io_filter_and_pulse regression: pass");
      else
         $display("digital_io_filter_and_pulse regression: fail");
      $finish;
   end

endmodule
